// File: hw/rtl/ght_pkg.sv
// Shared types, codes and constants of the generational handle table.
`default_nettype none

package ght_pkg;

  // Default sizing of the table
  localparam int NUM_SLOTS_DEF = 1024;
  localparam int GEN_SHIFT_DEF = 12;

  // Fixed field widths
  localparam int HANDLE_W = 31;
  localparam int SLOT_W   = 10;
  localparam int RUNS_W   = 32;
  localparam int STATUS_W = 2;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Request codes
  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_RUN    = 2'd3
  } req_type_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD     = 2'd1,
    STAT_NO_SLOT = 2'd2
  } status_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_EXEC  = 2'd2
  } back_state_t;

  // Classified request as queued between front and back
  typedef struct packed {
    req_type_t           op;
    logic                bad;        // index out of table range
    logic                hid_zero;   // lookup of the current slot
    logic                perm;
    logic [HANDLE_W-1:0] handle_id;
    logic [HANDLE_W-1:0] parent;
    logic [SLOT_W-1:0]   slot_index;
  } req_t;

endpackage

`default_nettype wire

// File: hw/rtl/generational_handle_table_unit.sv
// Top level of the generational handle table: front, queue and back end.
//
//   Channel   Ports                      Transfer
//   request   start / busy, in_*         rising edge with start high, busy low
//   result    out_valid, out_*           every cycle with out_valid high
//
// The back end takes one request at a time: in its idle state it pops the
// request and reads the slot memories at its slot; in the execute state it
// evaluates, writes back and registers the result. out_valid is registered
// from the execute state and rises together with the registered result.
// After reset a clearing pass over all NUM_SLOTS slots holds busy high.
// The queue takes two requests ahead of the back end; busy rises when it is
// full. Results are never stalled by the receiver.
`default_nettype none

module generational_handle_table_unit #(
  parameter int NUM_SLOTS = ght_pkg::NUM_SLOTS_DEF,
  parameter int GEN_SHIFT = ght_pkg::GEN_SHIFT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic [1:0]                   in_req_type,
  input  wire logic [ght_pkg::HANDLE_W-1:0] in_handle_id,
  input  wire logic [ght_pkg::HANDLE_W-1:0] in_parent_handle,
  input  wire logic [ght_pkg::SLOT_W-1:0]   in_slot_index,
  input  wire logic                         in_check_permission,
  output      logic                         out_valid,
  output      logic [ght_pkg::STATUS_W-1:0] out_status,
  output      logic [ght_pkg::HANDLE_W-1:0] out_result_handle,
  output      logic [ght_pkg::SLOT_W-1:0]   out_result_slot,
  output      logic                         out_has_slot,
  output      logic                         out_was_current,
  output      logic [ght_pkg::RUNS_W-1:0]   out_run_count
);

  import ght_pkg::*;

  logic push, pop, q_full, q_empty, clearing;
  req_t push_data, q_head;

  // Accept and classify requests
  ght_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
    .start               (start),
    .busy                (busy),
    .in_req_type         (in_req_type),
    .in_handle_id        (in_handle_id),
    .in_parent_handle    (in_parent_handle),
    .in_slot_index       (in_slot_index),
    .in_check_permission (in_check_permission),
    .q_full              (q_full),
    .back_clearing       (clearing),
    .push                (push),
    .push_data           (push_data)
  );

  // Buffer classified requests
  ght_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Execute requests against the slot table
  ght_back #(.NUM_SLOTS(NUM_SLOTS), .GEN_SHIFT(GEN_SHIFT)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_result_handle (out_result_handle),
    .out_result_slot   (out_result_slot),
    .out_has_slot      (out_has_slot),
    .out_was_current   (out_was_current),
    .out_run_count     (out_run_count)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ght_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/ght_front.sv
// Front end: accepts requests and classifies them for the queue.
`default_nettype none

module ght_front #(
  parameter int NUM_SLOTS = ght_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic [1:0]                   in_req_type,
  input  wire logic [ght_pkg::HANDLE_W-1:0] in_handle_id,
  input  wire logic [ght_pkg::HANDLE_W-1:0] in_parent_handle,
  input  wire logic [ght_pkg::SLOT_W-1:0]   in_slot_index,
  input  wire logic                         in_check_permission,
  input  wire logic                         q_full,
  input  wire logic                         back_clearing,
  output      logic                         push,
  output      ght_pkg::req_t                push_data
);

  import ght_pkg::*;

  localparam logic [31:0]         NUM_SLOTS_U = 32'(NUM_SLOTS);
  localparam logic [HANDLE_W-1:0] IDX_MASK    = HANDLE_W'(NUM_SLOTS - 1);

  logic [HANDLE_W-1:0] hid_idx;
  logic                slot_bad;
  logic                hid_bad;
  req_type_t           op;

  // Hold off requests while clearing or while the queue is full
  assign busy = q_full | back_clearing;
  assign push = start & ~busy;

  // Range checks on the two index sources
  assign op       = req_type_t'(in_req_type);
  assign hid_idx  = in_handle_id & IDX_MASK;
  assign slot_bad = 32'(in_slot_index) >= NUM_SLOTS_U;
  assign hid_bad  = 32'(hid_idx) >= NUM_SLOTS_U;

  // Classify the request
  always_comb begin
    push_data.op         = op;
    push_data.hid_zero   = (in_handle_id == '0);
    push_data.perm       = in_check_permission;
    push_data.handle_id  = in_handle_id;
    push_data.parent     = in_parent_handle;
    push_data.slot_index = in_slot_index;
    case (op)
      REQ_ALLOC:  push_data.bad = 1'b0;
      REQ_LOOKUP: push_data.bad = hid_bad & (in_handle_id != '0);
      default:    push_data.bad = slot_bad;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/ght_queue.sv
// Short request queue between the front and back ends.
`default_nettype none

module ght_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ght_pkg::req_t push_data,
  input  wire logic          pop,
  output      logic          full,
  output      logic          empty,
  output      ght_pkg::req_t head
);

  import ght_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  req_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ght_back.sv
// Back end: slot memories, free list and request execution.
`default_nettype none

module ght_back #(
  parameter int NUM_SLOTS = ght_pkg::NUM_SLOTS_DEF,
  parameter int GEN_SHIFT = ght_pkg::GEN_SHIFT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  input  wire ght_pkg::req_t                q_head,
  output      logic                         q_pop,
  output      logic                         clearing,
  output      logic                         out_valid,
  output      logic [ght_pkg::STATUS_W-1:0] out_status,
  output      logic [ght_pkg::HANDLE_W-1:0] out_result_handle,
  output      logic [ght_pkg::SLOT_W-1:0]   out_result_slot,
  output      logic                         out_has_slot,
  output      logic                         out_was_current,
  output      logic [ght_pkg::RUNS_W-1:0]   out_run_count
);

  import ght_pkg::*;

  localparam int IDX_W  = $clog2(NUM_SLOTS);
  localparam int LINK_W = IDX_W + 1;
  localparam logic [HANDLE_W-1:0] IDX_MASK  = HANDLE_W'(NUM_SLOTS - 1);
  localparam logic [31:0]         IDX_MASK32 = 32'(NUM_SLOTS - 1);
  localparam logic [31:0]         GEN_INC   = 32'd1 << GEN_SHIFT;
  localparam logic [LINK_W-1:0]   LINK_NULL = LINK_W'(NUM_SLOTS);
  localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(NUM_SLOTS - 1);

  back_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [LINK_W-1:0]   free_head_r, free_head_nxt;
  logic                cur_valid_r, cur_valid_nxt;
  logic [IDX_W-1:0]    cur_slot_r, cur_slot_nxt;
  logic [HANDLE_W-1:0] cur_handle_r, cur_handle_nxt;
  req_t                cmd_r;
  logic [IDX_W-1:0]    idx_r, rd_idx;
  logic                exec;

  // Memory ports
  logic [IDX_W-1:0]    wr_addr;
  logic                we_handle, we_parent, we_runs, we_live, we_link;
  logic [HANDLE_W-1:0] wd_handle, wd_parent, rd_handle, rd_parent;
  logic [RUNS_W-1:0]   wd_runs, rd_runs;
  logic                wd_live, rd_live;
  logic [LINK_W-1:0]   wd_link, rd_link;

  // Result of the executed request
  status_t             res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_has, res_wc;
  logic [RUNS_W-1:0]   res_runs;

  // Generation arithmetic and checks
  logic [31:0]         gen_sum, gen_raw, gen_val;
  logic [HANDLE_W-1:0] new_handle;
  logic [HANDLE_W-1:0] cur_h;
  logic [RUNS_W-1:0]   runs_inc;
  logic                same_cur;
  logic                no_free;

  // Next state of the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: if (clr_cnt_r == LAST_IDX) state_nxt = BK_IDLE;
      BK_IDLE:  if (!q_empty) state_nxt = BK_EXEC;
      BK_EXEC:  state_nxt = BK_IDLE;
      default:  state_nxt = BK_CLEAR;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop    = 1'b0;
    clearing = 1'b0;
    exec     = 1'b0;
    case (state_r)
      BK_CLEAR: clearing = 1'b1;
      BK_IDLE:  q_pop = ~q_empty;
      BK_EXEC:  exec = 1'b1;
      default:  clearing = 1'b1;
    endcase
  end

  // Pick the slot that the queued request touches
  always_comb begin
    case (q_head.op)
      REQ_ALLOC:  rd_idx = free_head_r[IDX_W-1:0];
      REQ_LOOKUP: rd_idx = IDX_W'(q_head.handle_id & IDX_MASK);
      default:    rd_idx = IDX_W'(q_head.slot_index);
    endcase
  end

  // Next generation of the slot handle
  assign gen_sum    = {1'b0, rd_handle} + GEN_INC;
  assign gen_raw    = gen_sum & ~IDX_MASK32;
  assign gen_val    = (gen_raw == '0 || gen_raw[31]) ? GEN_INC : gen_raw;
  assign new_handle = HANDLE_W'(gen_val | 32'(idx_r));

  assign same_cur = cur_valid_r && (cur_slot_r == idx_r);
  assign cur_h    = cur_valid_r ? cur_handle_r : '0;
  assign runs_inc = rd_runs + 1'b1;
  assign no_free  = (free_head_r >= LINK_NULL);
  assign clr_cnt_nxt = clearing ? clr_cnt_r + 1'b1 : clr_cnt_r;
  assign wr_addr  = clearing ? clr_cnt_r : idx_r;

  // Execute the request: memory writes, state updates, result
  always_comb begin
    res_status     = STAT_OK;
    res_handle     = '0;
    res_slot       = '0;
    res_has        = 1'b0;
    res_wc         = 1'b0;
    res_runs       = '0;
    we_handle      = 1'b0;
    we_parent      = 1'b0;
    we_runs        = 1'b0;
    we_live        = 1'b0;
    we_link        = 1'b0;
    wd_handle      = new_handle;
    wd_parent      = cmd_r.parent;
    wd_runs        = '0;
    wd_live        = 1'b0;
    wd_link        = free_head_r;
    free_head_nxt  = free_head_r;
    cur_valid_nxt  = cur_valid_r;
    cur_slot_nxt   = cur_slot_r;
    cur_handle_nxt = cur_handle_r;
    if (clearing) begin
      // Sweep the slot memories into their reset contents
      we_handle = 1'b1;
      we_parent = 1'b1;
      we_runs   = 1'b1;
      we_live   = 1'b1;
      we_link   = 1'b1;
      wd_handle = '0;
      wd_parent = '0;
      wd_link   = LINK_W'(clr_cnt_r) + 1'b1;
    end else if (exec) begin
      case (cmd_r.op)
        REQ_ALLOC: begin
          if (no_free) begin
            res_status = STAT_NO_SLOT;
          end else begin
            we_handle     = 1'b1;
            we_parent     = 1'b1;
            we_runs       = 1'b1;
            we_live       = 1'b1;
            wd_live       = 1'b1;
            free_head_nxt = rd_link;
            if (idx_r == cur_slot_r) begin
              cur_handle_nxt = new_handle;
            end
            res_handle = new_handle;
            res_slot   = SLOT_W'(idx_r);
            res_has    = 1'b1;
          end
        end
        REQ_FREE: begin
          if (cmd_r.bad || !rd_live) begin
            res_status = STAT_BAD;
          end else begin
            we_live       = 1'b1;
            we_link       = 1'b1;
            free_head_nxt = LINK_W'(idx_r);
            res_handle    = rd_handle;
            res_slot      = SLOT_W'(idx_r);
            res_has       = 1'b1;
            res_wc        = same_cur;
          end
        end
        REQ_LOOKUP: begin
          if (cmd_r.hid_zero) begin
            res_has    = cur_valid_r;
            res_handle = cur_h;
            res_slot   = cur_valid_r ? SLOT_W'(cur_slot_r) : '0;
          end else if (cmd_r.bad || !rd_live || rd_handle != cmd_r.handle_id) begin
            res_status = STAT_BAD;
          end else if (cmd_r.perm && !same_cur && rd_parent != cur_h) begin
            res_status = STAT_BAD;
          end else begin
            res_handle = rd_handle;
            res_slot   = SLOT_W'(idx_r);
            res_has    = 1'b1;
          end
        end
        default: begin
          // Run: switch the slot in unless it is already current
          if (cmd_r.bad || !rd_live) begin
            res_status = STAT_BAD;
          end else begin
            res_handle = rd_handle;
            res_slot   = SLOT_W'(idx_r);
            res_has    = 1'b1;
            if (same_cur) begin
              res_runs = rd_runs;
            end else begin
              we_runs        = 1'b1;
              wd_runs        = runs_inc;
              cur_valid_nxt  = 1'b1;
              cur_slot_nxt   = idx_r;
              cur_handle_nxt = rd_handle;
              res_runs       = runs_inc;
            end
          end
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_CLEAR;
      clr_cnt_r    <= '0;
      free_head_r  <= '0;
      cur_valid_r  <= 1'b0;
      cur_slot_r   <= '0;
      cur_handle_r <= '0;
      out_valid    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      free_head_r  <= free_head_nxt;
      cur_valid_r  <= cur_valid_nxt;
      cur_slot_r   <= cur_slot_nxt;
      cur_handle_r <= cur_handle_nxt;
      out_valid    <= exec;
    end
  end

  // Latch the popped request and register the result
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
      idx_r <= rd_idx;
    end
    if (exec) begin
      out_status        <= res_status;
      out_result_handle <= res_handle;
      out_result_slot   <= res_slot;
      out_has_slot      <= res_has;
      out_was_current   <= res_wc;
      out_run_count     <= res_runs;
    end
  end

  // Slot memories, all read at the popped request's slot
  ght_ram #(.WIDTH(HANDLE_W), .DEPTH(NUM_SLOTS)) u_handle_ram (
    .clk(clk), .we(we_handle), .wr_addr(wr_addr), .wr_data(wd_handle),
    .rd_addr(rd_idx), .rd_data(rd_handle)
  );

  ght_ram #(.WIDTH(HANDLE_W), .DEPTH(NUM_SLOTS)) u_parent_ram (
    .clk(clk), .we(we_parent), .wr_addr(wr_addr), .wr_data(wd_parent),
    .rd_addr(rd_idx), .rd_data(rd_parent)
  );

  ght_ram #(.WIDTH(RUNS_W), .DEPTH(NUM_SLOTS)) u_runs_ram (
    .clk(clk), .we(we_runs), .wr_addr(wr_addr), .wr_data(wd_runs),
    .rd_addr(rd_idx), .rd_data(rd_runs)
  );

  // One bit per slot: slot is in use (runnable or running)
  ght_ram #(.WIDTH(1), .DEPTH(NUM_SLOTS)) u_live_ram (
    .clk(clk), .we(we_live), .wr_addr(wr_addr), .wr_data(wd_live),
    .rd_addr(rd_idx), .rd_data(rd_live)
  );

  ght_ram #(.WIDTH(LINK_W), .DEPTH(NUM_SLOTS)) u_link_ram (
    .clk(clk), .we(we_link), .wr_addr(wr_addr), .wr_data(wd_link),
    .rd_addr(rd_idx), .rd_data(rd_link)
  );

endmodule

`default_nettype wire
